// ===== sv/ferl_pkg.sv =====
package ferl_pkg;

  localparam int DEF_CAPACITY = 256;
  localparam int CFG_IDX_W    = 3;

  localparam logic [7:0] WILDCARD = 8'hFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_START = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_END   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAST_SEV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_KIND  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_UNIT  = 3'd4;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_QUERY  = 2'd1,
    OP_FETCH  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPEND,
    ST_OLDEST,
    ST_WALK,
    ST_RESULT
  } state_t;

  typedef struct packed {
    op_t         operation;
    logic [63:0] event_time;
    logic [7:0]  event_severity;
    logic [7:0]  event_source_kind;
    logic [7:0]  event_source_unit;
    logic [31:0] event_code_in;
    logic [63:0] now_time;
  } in_word_t;

  typedef struct packed {
    logic        status;
    logic [63:0] out_time;
    logic [7:0]  out_severity;
    logic [7:0]  out_source_kind;
    logic [7:0]  out_source_unit;
    logic [31:0] out_code;
    logic [31:0] out_sequence;
    logic [8:0]  match_total;
    logic [8:0]  stored_total;
    logic [63:0] oldest_seen;
    logic [63:0] newest_seen;
  } out_word_t;

  typedef struct packed {
    logic [63:0] ev_time;
    logic [7:0]  severity;
    logic [7:0]  source_kind;
    logic [7:0]  source_unit;
    logic [31:0] code;
    logic [31:0] seq_num;
  } entry_t;

  typedef struct packed {
    logic [63:0] window_start;
    logic [63:0] window_end;
    logic [7:0]  least_severity;
    logic [7:0]  match_source_kind;
    logic [7:0]  match_source_unit;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic take;         // latch word, set up the walk
    logic do_append;    // write slot, update pointers and times
    logic take_oldest;  // reload oldest time from read data
    logic walk;         // issue and evaluate scan reads
    logic load_out;     // load the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic walk_done;
  } sts_t;

  function automatic logic ev_pass(input entry_t e, input cfg_t c);
    logic ok;
    ok = 1'b1;
    if (c.window_start != 64'd0 && e.ev_time < c.window_start) ok = 1'b0;
    if (c.window_end != 64'd0 && e.ev_time > c.window_end) ok = 1'b0;
    if (e.severity < c.least_severity) ok = 1'b0;
    if (c.match_source_kind != WILDCARD && e.source_kind != c.match_source_kind) ok = 1'b0;
    if (c.match_source_unit != WILDCARD && e.source_unit != c.match_source_unit) ok = 1'b0;
    return ok;
  endfunction

endpackage

// ===== sv/filtered_event_ring_log.sv =====
// Sequence: an append writes its slot and, when the ring is full, reads back the new
//   oldest time; query and fetch walk the stored entries through the read port; the
//   unused opcode goes straight to the result. Each then loads the result register.
// Throughput: one word at a time; the next word is taken in the cycle after the result
//   loads, walks read one entry per cycle through the single read port, and a result
//   still stalled downstream holds the next load.
// Reset (rst_n low, synchronous): pointers, counts, times and filters clear (source
//   matches go to the wildcard), sequence restarts at 1; the event store is not cleared.
module filtered_event_ring_log
  import ferl_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // request words
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  // result words
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  // filter register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  cmd_t cmd;
  sts_t sts;

  // Filter registers take a write whenever one is offered, so the port never holds off.
  assign cfg_ready = 1'b1;

  // Controller: take a word only in idle, sequence the append write and the
  // oldest-time reload, run the scan walk, then park the result in the output
  // register. A new word may be taken while that result still waits downstream.
  ferl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: event store, ring pointers, timestamp tracking, filter registers
  // and the scan pipeline (issue read, evaluate filter on registered data).
  ferl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

// ===== sv/ferl_ctrl.sv =====
module ferl_ctrl
  import ferl_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  op_t  in_op,
  output logic in_stall,
  input  logic out_stall,
  output logic out_valid,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_APPEND: state_nxt = ST_APPEND;
            OP_QUERY:  state_nxt = ST_WALK;
            OP_FETCH:  state_nxt = ST_WALK;
            default:   state_nxt = ST_RESULT;
          endcase
        end
      end
      ST_APPEND: state_nxt = sts.full ? ST_OLDEST : ST_RESULT;
      ST_OLDEST: state_nxt = ST_RESULT;
      ST_WALK:   if (sts.walk_done) state_nxt = ST_RESULT;
      ST_RESULT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.take = in_valid;
      end
      ST_APPEND: cmd.do_append   = 1'b1;
      ST_OLDEST: cmd.take_oldest = 1'b1;
      ST_WALK:   cmd.walk        = 1'b1;
      ST_RESULT: cmd.load_out    = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== sv/ferl_dp.sv =====
module ferl_dp
  import ferl_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_word_t             in_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  output out_word_t            out_data
);

  localparam int PTR_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(CAPACITY);

  function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + 1'b1;
  endfunction

  entry_t mem [CAPACITY];

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] old_ptr_r, old_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [31:0]      seq_r, seq_nxt;
  logic [63:0]      old_time_r, old_time_nxt;
  logic [63:0]      new_time_r, new_time_nxt;
  logic [PTR_W-1:0] scan_ptr_r, scan_ptr_nxt;
  logic [CNT_W-1:0] scan_done_r, scan_done_nxt;
  cfg_t             cfg_r, cfg_nxt;
  logic [PTR_W-1:0] iss_ptr_r, iss_ptr_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic             rd_valid_r, rd_valid_nxt;
  logic             found_r, found_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  in_word_t  req_r;
  entry_t    rd_data_r;
  out_word_t out_r;
  out_word_t res_word;

  logic             full;
  logic             is_fetch;
  logic             hit;
  logic             eval_en;
  logic             issue_en;
  logic             mem_rd_en;
  logic [PTR_W-1:0] mem_rd_addr;
  logic [63:0]      app_time;
  entry_t           app_entry;

  assign full     = (fill_r == FULL_CNT);
  assign is_fetch = (req_r.operation == OP_FETCH);
  assign hit      = ev_pass(rd_data_r, cfg_r);
  assign eval_en  = cmd.walk && rd_valid_r && !found_r;
  // stop issuing once a fetch hits, so the read register keeps the hit
  assign issue_en = cmd.walk && (remain_r != '0) && !found_r && !(is_fetch && eval_en && hit);

  assign app_time = (req_r.event_time != 64'd0) ? req_r.event_time : req_r.now_time;

  always_comb begin
    app_entry.ev_time     = app_time;
    app_entry.severity    = req_r.event_severity;
    app_entry.source_kind = req_r.event_source_kind;
    app_entry.source_unit = req_r.event_source_unit;
    app_entry.code        = req_r.event_code_in;
    app_entry.seq_num     = seq_r;
  end

  assign mem_rd_en   = issue_en || (cmd.do_append && full);
  assign mem_rd_addr = cmd.do_append ? adv(old_ptr_r) : iss_ptr_r;

  always_comb begin
    wr_ptr_nxt    = wr_ptr_r;
    old_ptr_nxt   = old_ptr_r;
    fill_nxt      = fill_r;
    seq_nxt       = seq_r;
    old_time_nxt  = old_time_r;
    new_time_nxt  = new_time_r;
    scan_ptr_nxt  = scan_ptr_r;
    scan_done_nxt = scan_done_r;
    cfg_nxt       = cfg_r;
    iss_ptr_nxt   = iss_ptr_r;
    remain_nxt    = remain_r;
    rd_valid_nxt  = rd_valid_r;
    found_nxt     = found_r;
    count_nxt     = count_r;

    if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_START: cfg_nxt.window_start      = cfg_data;
        CFG_WINDOW_END:   cfg_nxt.window_end        = cfg_data;
        CFG_LEAST_SEV:    cfg_nxt.least_severity    = cfg_data[7:0];
        CFG_SOURCE_KIND:  cfg_nxt.match_source_kind = cfg_data[7:0];
        CFG_SOURCE_UNIT:  cfg_nxt.match_source_unit = cfg_data[7:0];
        default: ;
      endcase
    end

    if (cmd.take) begin
      rd_valid_nxt = 1'b0;
      found_nxt    = 1'b0;
      count_nxt    = '0;
      if (in_data.operation == OP_QUERY) begin
        iss_ptr_nxt   = old_ptr_r;
        remain_nxt    = fill_r;
        scan_ptr_nxt  = old_ptr_r;
        scan_done_nxt = '0;
      end else begin
        iss_ptr_nxt = scan_ptr_r;
        remain_nxt  = fill_r - scan_done_r;
      end
    end

    if (cmd.do_append) begin
      seq_nxt    = seq_r + 32'd1;
      wr_ptr_nxt = adv(wr_ptr_r);
      if (fill_r == '0 || app_time < old_time_r) old_time_nxt = app_time;
      if (app_time > new_time_r) new_time_nxt = app_time;
      if (full) old_ptr_nxt = adv(old_ptr_r);
      else fill_nxt = fill_r + 1'b1;
    end

    if (cmd.take_oldest) old_time_nxt = rd_data_r.ev_time;

    if (cmd.walk) begin
      rd_valid_nxt = issue_en;
      if (issue_en) begin
        iss_ptr_nxt = adv(iss_ptr_r);
        remain_nxt  = remain_r - 1'b1;
      end
      if (eval_en) begin
        if (is_fetch) begin
          scan_ptr_nxt  = adv(scan_ptr_r);
          scan_done_nxt = scan_done_r + 1'b1;
          if (hit) found_nxt = 1'b1;
        end else if (hit) begin
          count_nxt = count_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r                <= '0;
      old_ptr_r               <= '0;
      fill_r                  <= '0;
      seq_r                   <= 32'd1;
      old_time_r              <= '0;
      new_time_r              <= '0;
      scan_ptr_r              <= '0;
      scan_done_r             <= '0;
      cfg_r.window_start      <= '0;
      cfg_r.window_end        <= '0;
      cfg_r.least_severity    <= '0;
      cfg_r.match_source_kind <= WILDCARD;
      cfg_r.match_source_unit <= WILDCARD;
      iss_ptr_r               <= '0;
      remain_r                <= '0;
      rd_valid_r              <= 1'b0;
      found_r                 <= 1'b0;
      count_r                 <= '0;
    end else begin
      wr_ptr_r    <= wr_ptr_nxt;
      old_ptr_r   <= old_ptr_nxt;
      fill_r      <= fill_nxt;
      seq_r       <= seq_nxt;
      old_time_r  <= old_time_nxt;
      new_time_r  <= new_time_nxt;
      scan_ptr_r  <= scan_ptr_nxt;
      scan_done_r <= scan_done_nxt;
      cfg_r       <= cfg_nxt;
      iss_ptr_r   <= iss_ptr_nxt;
      remain_r    <= remain_nxt;
      rd_valid_r  <= rd_valid_nxt;
      found_r     <= found_nxt;
      count_r     <= count_nxt;
    end
  end

  // event store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.do_append) mem[wr_ptr_r] <= app_entry;
    if (mem_rd_en) rd_data_r <= mem[mem_rd_addr];
  end

  always_comb begin
    res_word              = '0;
    res_word.stored_total = 9'(fill_r);
    res_word.oldest_seen  = old_time_r;
    res_word.newest_seen  = new_time_r;
    case (req_r.operation)
      OP_APPEND: begin
        res_word.out_time        = app_time;
        res_word.out_severity    = req_r.event_severity;
        res_word.out_source_kind = req_r.event_source_kind;
        res_word.out_source_unit = req_r.event_source_unit;
        res_word.out_code        = req_r.event_code_in;
        res_word.out_sequence    = seq_r - 32'd1;
      end
      OP_QUERY: res_word.match_total = 9'(count_r);
      OP_FETCH: begin
        if (found_r) begin
          res_word.out_time        = rd_data_r.ev_time;
          res_word.out_severity    = rd_data_r.severity;
          res_word.out_source_kind = rd_data_r.source_kind;
          res_word.out_source_unit = rd_data_r.source_unit;
          res_word.out_code        = rd_data_r.code;
          res_word.out_sequence    = rd_data_r.seq_num;
        end else begin
          res_word.status = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take) req_r <= in_data;
    if (cmd.load_out) out_r <= res_word;
  end

  assign sts.full      = full;
  assign sts.walk_done = found_r || (remain_r == '0 && !rd_valid_r);
  assign out_data      = out_r;

endmodule

// ===== sv/ferl_chk.sv =====
module ferl_chk
  import ferl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  // one word in flight: after a take the input side holds off
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken before the first finished");

  // oldest stored time never exceeds the newest
  a_time_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.oldest_seen <= out_data.newest_seen)
    else $error("oldest time above newest time");

  // a miss carries no event and no count
  a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      out_data.out_sequence == 32'd0 && out_data.match_total == 9'd0 &&
      out_data.out_code == 32'd0)
    else $error("miss result carries event data");

  // a count result carries no event
  a_count_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.match_total != 9'd0 |->
      !out_data.status && out_data.out_sequence == 32'd0)
    else $error("count result carries event data");

endmodule

bind filtered_event_ring_log ferl_chk u_ferl_chk (.*);
